>>> src/qrc_pkg.sv
`timescale 1ns / 1ps
// Shared types, widths and constants for the quadrilateral rectangle check.
// No dependencies; imported by every module of the block.
package qrc_pkg;

  localparam int COORD_W  = 16;                   // signed fixed-point corner coordinate
  localparam int FRAC_W   = 4;                    // fraction bits of a coordinate
  localparam int LIM_W    = 12;                   // side limit registers, whole pixels
  localparam int SUM_W    = COORD_W + 2;          // sum of four coordinates
  localparam int SIDE_W   = COORD_W + 1;          // difference of two coordinates
  localparam int PROD_W   = 2 * SIDE_W;           // product of two sides
  localparam int DOT_W    = PROD_W + 1;           // dot or cross product
  localparam int TRUNC_W  = DOT_W - 2 * FRAC_W;   // dot or cross in whole square pixels
  localparam int MAG_W    = TRUNC_W;              // magnitude of the above
  localparam int LIM_SQ_W = 2 * LIM_W;
  localparam int LIM2_W   = LIM_SQ_W + 2 * FRAC_W;
  localparam int TAN_W    = 18;
  localparam int ONE_SH   = 20;                   // tangent constants are Q20
  localparam int KPROD_W  = MAG_W + TAN_W;
  localparam int CMP_W    = MAG_W + ONE_SH;

  // tan(90 - 80 * 3.14 / 180) and tan(100 * 3.14 / 180 - 90), Q20
  localparam logic [TAN_W-1:0] TAN_LOW  = TAN_W'(185658);
  localparam logic [TAN_W-1:0] TAN_HIGH = TAN_W'(183936);

  localparam logic [LIM_W-1:0] MIN_SIDE_RST  = LIM_W'(50);
  localparam logic [LIM_W-1:0] NEAR_SIDE_RST = LIM_W'(100);

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIDE  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_NEAR_SIDE = 1'b1;

  typedef enum logic [1:0] {
    MATCH_BAD    = 2'd0,
    MATCH_GOOD   = 2'd1,
    MATCH_ACCEPT = 2'd2
  } match_code_t;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic signed [SIDE_W-1:0]  side_t;
  typedef logic signed [PROD_W-1:0]  prod_t;
  typedef logic [MAG_W-1:0]          mag_t;
  typedef logic [LIM2_W-1:0]         lim2_t;

  typedef struct packed {
    coord_t corner0_x;
    coord_t corner0_y;
    coord_t corner1_x;
    coord_t corner1_y;
    coord_t corner2_x;
    coord_t corner2_y;
    coord_t corner3_x;
    coord_t corner3_y;
  } in_req_t;

  typedef struct packed {
    match_code_t match_code;
    coord_t      center_x;
    coord_t      center_y;
  } out_rsp_t;

  // corners ordered by quadrant, plus centroid
  typedef struct packed {
    logic           quad_ok;
    coord_t         cx;
    coord_t         cy;
    logic [3:0][COORD_W-1:0] qx;
    logic [3:0][COORD_W-1:0] qy;
  } sort_t;

  // per-corner angle terms and side length flags
  typedef struct packed {
    logic                  quad_ok;
    coord_t                cx;
    coord_t                cy;
    logic [3:0]            dot_neg;
    logic [3:0][MAG_W-1:0] dot_mag;
    logic [3:0][MAG_W-1:0] crs_mag;
    logic [3:0]            long_ok;
    logic [3:0]            near_ok;
  } geom_t;

endpackage

>>> src/qrc_sort.sv
`timescale 1ns / 1ps
// Front two stages: centroid sums, then quadrant sort of the four corners.
// Depends on qrc_pkg.
module qrc_sort (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_vld,
  output logic             in_rdy,
  input  qrc_pkg::in_req_t in_data,
  output logic             out_vld,
  input  logic             out_rdy,
  output qrc_pkg::sort_t   out_data
);
  import qrc_pkg::*;

  logic               s1_vld_r;
  in_req_t            s1_data_r;
  logic [SUM_W-1:0]   s1_sumx_r, s1_sumy_r;
  logic [SUM_W-1:0]   sumx_nxt, sumy_nxt;
  logic               s2_vld_r;
  sort_t              s2_data_r;
  sort_t              s2_nxt;
  logic               s1_adv, s2_adv;

  coord_t             px [4];
  coord_t             py [4];
  logic signed [SUM_W-1:0] x4 [4];
  logic signed [SUM_W-1:0] y4 [4];
  logic [3:0][3:0]    hit;     // [quadrant][corner]
  logic [3:0]         one_hit;

  assign s2_adv = !s2_vld_r || out_rdy;
  assign s1_adv = !s1_vld_r || s2_adv;
  assign in_rdy = s1_adv;

  assign sumx_nxt = SUM_W'(in_data.corner0_x) + SUM_W'(in_data.corner1_x)
                  + SUM_W'(in_data.corner2_x) + SUM_W'(in_data.corner3_x);
  assign sumy_nxt = SUM_W'(in_data.corner0_y) + SUM_W'(in_data.corner1_y)
                  + SUM_W'(in_data.corner2_y) + SUM_W'(in_data.corner3_y);

  assign px[0] = s1_data_r.corner0_x;
  assign py[0] = s1_data_r.corner0_y;
  assign px[1] = s1_data_r.corner1_x;
  assign py[1] = s1_data_r.corner1_y;
  assign px[2] = s1_data_r.corner2_x;
  assign py[2] = s1_data_r.corner2_y;
  assign px[3] = s1_data_r.corner3_x;
  assign py[3] = s1_data_r.corner3_y;

  // strict compares: a corner on a centroid line lands in no quadrant
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      x4[i] = $signed({px[i], 2'b00});
      y4[i] = $signed({py[i], 2'b00});
      hit[0][i] = (x4[i] < $signed(s1_sumx_r)) && (y4[i] < $signed(s1_sumy_r));
      hit[1][i] = (x4[i] < $signed(s1_sumx_r)) && (y4[i] > $signed(s1_sumy_r));
      hit[2][i] = (x4[i] > $signed(s1_sumx_r)) && (y4[i] > $signed(s1_sumy_r));
      hit[3][i] = (x4[i] > $signed(s1_sumx_r)) && (y4[i] < $signed(s1_sumy_r));
    end
    for (int k = 0; k < 4; k++) begin
      one_hit[k] = (hit[k] != 4'd0) && ((hit[k] & (hit[k] - 4'd1)) == 4'd0);
      s2_nxt.qx[k] = '0;
      s2_nxt.qy[k] = '0;
      for (int i = 0; i < 4; i++) begin
        if (hit[k][i]) begin
          s2_nxt.qx[k] = s2_nxt.qx[k] | px[i];
          s2_nxt.qy[k] = s2_nxt.qy[k] | py[i];
        end
      end
    end
    s2_nxt.quad_ok = &one_hit;
    // arithmetic shift by two is the floored average
    s2_nxt.cx = s1_sumx_r[SUM_W-1:2];
    s2_nxt.cy = s1_sumy_r[SUM_W-1:2];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
    end else begin
      if (s1_adv) s1_vld_r <= in_vld;
      if (s2_adv) s2_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && in_vld) begin
      s1_data_r <= in_data;
      s1_sumx_r <= sumx_nxt;
      s1_sumy_r <= sumy_nxt;
    end
    if (s2_adv && s1_vld_r) begin
      s2_data_r <= s2_nxt;
    end
  end

  assign out_vld  = s2_vld_r;
  assign out_data = s2_data_r;

endmodule

>>> src/qrc_geom.sv
`timescale 1ns / 1ps
// Middle three stages: side vectors, pairwise products, then truncated
// dot/cross magnitudes and side length flags. Depends on qrc_pkg.
module qrc_geom (
  input  logic               clk,
  input  logic               rst_n,
  input  qrc_pkg::lim2_t     min_sq,
  input  qrc_pkg::lim2_t     near_sq,
  input  logic               in_vld,
  output logic               in_rdy,
  input  qrc_pkg::sort_t     in_data,
  output logic               out_vld,
  input  logic               out_rdy,
  output qrc_pkg::geom_t     out_data
);
  import qrc_pkg::*;

  localparam logic [DOT_W-1:0] TRUNC_BIAS = DOT_W'((1 << (2 * FRAC_W)) - 1);

  logic   s3_vld_r, s4_vld_r, s5_vld_r;
  logic   s3_adv, s4_adv, s5_adv;
  logic   s3_ok_r, s4_ok_r;
  coord_t s3_cx_r, s3_cy_r, s4_cx_r, s4_cy_r;
  side_t  sx_r [4];
  side_t  sy_r [4];
  side_t  sx_nxt [4];
  side_t  sy_nxt [4];
  prod_t  pxx_r [4];
  prod_t  pyy_r [4];
  prod_t  pxy_r [4];
  prod_t  pyx_r [4];
  prod_t  sqx_r [4];
  prod_t  sqy_r [4];
  geom_t  s5_data_r;
  geom_t  s5_nxt;

  logic signed [DOT_W-1:0]   dot [4];
  logic signed [DOT_W-1:0]   crs [4];
  logic signed [DOT_W-1:0]   dot_adj [4];
  logic signed [DOT_W-1:0]   crs_adj [4];
  logic signed [TRUNC_W-1:0] dot_t [4];
  logic signed [TRUNC_W-1:0] crs_t [4];
  logic [PROD_W-1:0]         len2 [4];

  assign s5_adv = !s5_vld_r || out_rdy;
  assign s4_adv = !s4_vld_r || s5_adv;
  assign s3_adv = !s3_vld_r || s4_adv;
  assign in_rdy = s3_adv;

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sx_nxt[i] = SIDE_W'($signed(in_data.qx[i])) - SIDE_W'($signed(in_data.qx[(i + 1) % 4]));
      sy_nxt[i] = SIDE_W'($signed(in_data.qy[i])) - SIDE_W'($signed(in_data.qy[(i + 1) % 4]));
    end
  end

  // division by 2^2F towards zero: bias negatives before the shift
  always_comb begin
    s5_nxt.quad_ok = s4_ok_r;
    s5_nxt.cx      = s4_cx_r;
    s5_nxt.cy      = s4_cy_r;
    for (int i = 0; i < 4; i++) begin
      dot[i]     = DOT_W'(pxx_r[i]) + DOT_W'(pyy_r[i]);
      crs[i]     = DOT_W'(pxy_r[i]) - DOT_W'(pyx_r[i]);
      dot_adj[i] = dot[i] + (dot[i][DOT_W-1] ? $signed(TRUNC_BIAS) : $signed(DOT_W'(0)));
      crs_adj[i] = crs[i] + (crs[i][DOT_W-1] ? $signed(TRUNC_BIAS) : $signed(DOT_W'(0)));
      dot_t[i]   = dot_adj[i][DOT_W-1:2*FRAC_W];
      crs_t[i]   = crs_adj[i][DOT_W-1:2*FRAC_W];
      s5_nxt.dot_neg[i] = dot_t[i][TRUNC_W-1];
      s5_nxt.dot_mag[i] = dot_t[i][TRUNC_W-1] ? MAG_W'(-dot_t[i]) : MAG_W'(dot_t[i]);
      s5_nxt.crs_mag[i] = crs_t[i][TRUNC_W-1] ? MAG_W'(-crs_t[i]) : MAG_W'(crs_t[i]);
      len2[i] = $unsigned(sqx_r[i]) + $unsigned(sqy_r[i]);
      s5_nxt.long_ok[i] = len2[i] > PROD_W'(min_sq);
      s5_nxt.near_ok[i] = len2[i] < PROD_W'(near_sq);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
    end else begin
      if (s3_adv) s3_vld_r <= in_vld;
      if (s4_adv) s4_vld_r <= s3_vld_r;
      if (s5_adv) s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_adv && in_vld) begin
      s3_ok_r <= in_data.quad_ok;
      s3_cx_r <= in_data.cx;
      s3_cy_r <= in_data.cy;
      for (int i = 0; i < 4; i++) begin
        sx_r[i] <= sx_nxt[i];
        sy_r[i] <= sy_nxt[i];
      end
    end
    if (s4_adv && s3_vld_r) begin
      s4_ok_r <= s3_ok_r;
      s4_cx_r <= s3_cx_r;
      s4_cy_r <= s3_cy_r;
      for (int i = 0; i < 4; i++) begin
        pxx_r[i] <= sx_r[i] * sx_r[(i + 1) % 4];
        pyy_r[i] <= sy_r[i] * sy_r[(i + 1) % 4];
        pxy_r[i] <= sx_r[i] * sy_r[(i + 1) % 4];
        pyx_r[i] <= sy_r[i] * sx_r[(i + 1) % 4];
        sqx_r[i] <= sx_r[i] * sx_r[i];
        sqy_r[i] <= sy_r[i] * sy_r[i];
      end
    end
    if (s5_adv && s4_vld_r) begin
      s5_data_r <= s5_nxt;
    end
  end

  assign out_vld  = s5_vld_r;
  assign out_data = s5_data_r;

endmodule

>>> src/qrc_judge.sv
`timescale 1ns / 1ps
// Last two stages: tangent products for the angle window, then the match
// decision into the output register. Depends on qrc_pkg.
module qrc_judge (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_vld,
  output logic               in_rdy,
  input  qrc_pkg::geom_t     in_data,
  output logic               out_vld,
  input  logic               out_rdy,
  output qrc_pkg::out_rsp_t  out_data
);
  import qrc_pkg::*;

  logic                s6_vld_r, s7_vld_r;
  logic                s6_adv, s7_adv;
  logic                s6_ok_r;
  coord_t              s6_cx_r, s6_cy_r;
  logic [KPROD_W-1:0]  kp_r [4];
  mag_t                dmag_r [4];
  logic [3:0]          crs_zero_r;
  logic [3:0]          long_r, near_r;
  out_rsp_t            s7_data_r;
  out_rsp_t            s7_nxt;
  logic [3:0]          angle_ok;
  match_code_t         code;

  assign s7_adv = !s7_vld_r || out_rdy;
  assign s6_adv = !s6_vld_r || s7_adv;
  assign in_rdy = s6_adv;

  // pass iff cross != 0 and |dot| * 2^20 <= |cross| * tan
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      angle_ok[i] = !crs_zero_r[i] &&
                    ((CMP_W'(dmag_r[i]) << ONE_SH) <= CMP_W'(kp_r[i]));
    end
    priority if (!s6_ok_r) begin
      code = MATCH_BAD;
    end else if ((&angle_ok) && (&long_r)) begin
      code = MATCH_ACCEPT;
    end else if (&near_r) begin
      code = MATCH_GOOD;
    end else begin
      code = MATCH_BAD;
    end
    s7_nxt.match_code = code;
    s7_nxt.center_x   = (code != MATCH_BAD) ? s6_cx_r : '0;
    s7_nxt.center_y   = (code != MATCH_BAD) ? s6_cy_r : '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
      s7_vld_r <= 1'b0;
    end else begin
      if (s6_adv) s6_vld_r <= in_vld;
      if (s7_adv) s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s6_adv && in_vld) begin
      s6_ok_r <= in_data.quad_ok;
      s6_cx_r <= in_data.cx;
      s6_cy_r <= in_data.cy;
      long_r  <= in_data.long_ok;
      near_r  <= in_data.near_ok;
      for (int i = 0; i < 4; i++) begin
        kp_r[i]       <= KPROD_W'(in_data.crs_mag[i]) *
                         KPROD_W'(in_data.dot_neg[i] ? TAN_HIGH : TAN_LOW);
        dmag_r[i]     <= in_data.dot_mag[i];
        crs_zero_r[i] <= (in_data.crs_mag[i] == '0);
      end
    end
    if (s7_adv && s6_vld_r) begin
      s7_data_r <= s7_nxt;
    end
  end

  assign out_vld  = s7_vld_r;
  assign out_data = s7_data_r;

endmodule

>>> src/quad_rectangle_check.sv
`timescale 1ns / 1ps
// Throughput: one request per cycle unless the output is stalled; seven register
// stages, each with its own valid bit, so bubbles close up when the output is stalled.
// Reset (rst_n low, synchronous) empties the pipeline and loads the side
// limits with 50 and 100 pixels. Depends on qrc_pkg, qrc_sort, qrc_geom, qrc_judge.
module quad_rectangle_check (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  qrc_pkg::in_req_t                    in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output qrc_pkg::out_rsp_t                   out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qrc_pkg::LIM_W-1:0]           cfg_data
);
  import qrc_pkg::*;

  logic [LIM_W-1:0] cfg_min_r, cfg_near_r;
  lim2_t            min_sq_r, near_sq_r;
  logic             sort_vld, sort_rdy, geom_vld, geom_rdy, in_rdy;
  sort_t            sort_data;
  geom_t            geom_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_min_r  <= MIN_SIDE_RST;
      cfg_near_r <= NEAR_SIDE_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_MIN_SIDE:  cfg_min_r  <= cfg_data;
        CFG_NEAR_SIDE: cfg_near_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared limits in 2^-2F pixel units; settle long before an item needs them
  always_ff @(posedge clk) begin
    min_sq_r  <= LIM2_W'(LIM_SQ_W'(cfg_min_r) * LIM_SQ_W'(cfg_min_r)) << (2 * FRAC_W);
    near_sq_r <= LIM2_W'(LIM_SQ_W'(cfg_near_r) * LIM_SQ_W'(cfg_near_r)) << (2 * FRAC_W);
  end

  qrc_sort u_sort (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (in_valid),
    .in_rdy   (in_rdy),
    .in_data  (in_data),
    .out_vld  (sort_vld),
    .out_rdy  (sort_rdy),
    .out_data (sort_data)
  );

  qrc_geom u_geom (
    .clk      (clk),
    .rst_n    (rst_n),
    .min_sq   (min_sq_r),
    .near_sq  (near_sq_r),
    .in_vld   (sort_vld),
    .in_rdy   (sort_rdy),
    .in_data  (sort_data),
    .out_vld  (geom_vld),
    .out_rdy  (geom_rdy),
    .out_data (geom_data)
  );

  qrc_judge u_judge (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_vld   (geom_vld),
    .in_rdy   (geom_rdy),
    .in_data  (geom_data),
    .out_vld  (out_valid),
    .out_rdy  (!out_stall),
    .out_data (out_data)
  );

  assign in_stall = !in_rdy;

`ifndef ASSERT_OFF
  // a bad match never carries a centroid
  a_bad_zero_centre: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.match_code == MATCH_BAD) |->
      (out_data.center_x == '0) && (out_data.center_y == '0))
    else $error("bad match with nonzero centroid");

  // input can only be held off when the pipeline is full behind a stalled result
  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled while pipeline has room");

  // reset empties the pipeline
  a_reset_empties: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");
`endif

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 1ps
// Self-checking bench for quad_rectangle_check: directed corner sets, then random
// quadrilaterals under several side-limit settings, with random input gaps and output stalls.
// Depends on qrc_pkg and the quad_rectangle_check RTL.
module tb_top;
  import qrc_pkg::*;

  // tan(90 - 80 * 3.14 / 180) and tan(100 * 3.14 / 180 - 90), Q20
  localparam longint TanAcuteQ20  = 185658;
  localparam longint TanObtuseQ20 = 183936;
  localparam int     PhaseItems   = 137;
  localparam int     Phases       = 5;

  typedef struct {
    in_req_t  req;
    bit       typed;
    out_rsp_t rsp;
  } corner_row_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_req_t              in_data = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_rsp_t             out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_MIN_SIDE;
  logic [LIM_W-1:0]     cfg_data = '0;

  logic [LIM_W-1:0] min_side_px = 12'd50;
  logic [LIM_W-1:0] near_side_px = 12'd100;
  out_rsp_t         expected_rsp[$];
  corner_row_t      corner_table[$];
  int               mismatches = 0;
  int               burst_left = 4;
  int               stall_mode = 0;
  int               stall_run = 0;

  quad_rectangle_check dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic in_req_t make_quad(coord_t x0, coord_t y0, coord_t x1, coord_t y1,
                                        coord_t x2, coord_t y2, coord_t x3, coord_t y3);
    in_req_t r;
    r.corner0_x = x0; r.corner0_y = y0;
    r.corner1_x = x1; r.corner1_y = y1;
    r.corner2_x = x2; r.corner2_y = y2;
    r.corner3_x = x3; r.corner3_y = y3;
    return r;
  endfunction

  function automatic out_rsp_t rsp(match_code_t code, coord_t cx, coord_t cy);
    out_rsp_t r;
    r.match_code = code;
    r.center_x = cx;
    r.center_y = cy;
    return r;
  endfunction

  task automatic add_row(input in_req_t req, input bit typed, input out_rsp_t want);
    corner_row_t row;
    row.req = req;
    row.typed = typed;
    row.rsp = want;
    corner_table.insert(corner_table.size(), row);
  endtask

  // turning angle between consecutive sides within 80..100 degrees either way
  function automatic bit turn_in_window(longint ax, longint ay, longint bx, longint by);
    longint dotp, crsp, dmag;
    dotp = (ax * bx + ay * by) / (longint'(1) << (2 * FRAC_W));
    crsp = (ax * by - ay * bx) / (longint'(1) << (2 * FRAC_W));
    dmag = (crsp < 0) ? -crsp : crsp;
    if (dmag == 0) return 1'b0;
    if (dotp >= 0) return (dotp << 20) <= dmag * TanAcuteQ20;
    return ((-dotp) << 20) <= dmag * TanObtuseQ20;
  endfunction

  function automatic out_rsp_t classify_quad(in_req_t c, logic [LIM_W-1:0] min_side,
                                             logic [LIM_W-1:0] near_side);
    longint px[4], py[4], qx[4], qy[4], sx[4], sy[4];
    longint sumx, sumy, min2, near2, len2;
    int cnt[4];
    int quad, angles, longs, nears, j;
    out_rsp_t r;
    px[0] = longint'(c.corner0_x); py[0] = longint'(c.corner0_y);
    px[1] = longint'(c.corner1_x); py[1] = longint'(c.corner1_y);
    px[2] = longint'(c.corner2_x); py[2] = longint'(c.corner2_y);
    px[3] = longint'(c.corner3_x); py[3] = longint'(c.corner3_y);
    sumx = 0; sumy = 0;
    angles = 0; longs = 0; nears = 0;
    for (int i = 0; i < 4; i++) begin
      sumx += px[i];
      sumy += py[i];
      cnt[i] = 0;
      qx[i] = 0;
      qy[i] = 0;
    end
    // quadrants around the centroid, strict on both axes
    for (int i = 0; i < 4; i++) begin
      quad = -1;
      if (px[i] * 4 < sumx && py[i] * 4 < sumy) quad = 0;
      else if (px[i] * 4 < sumx && py[i] * 4 > sumy) quad = 1;
      else if (px[i] * 4 > sumx && py[i] * 4 > sumy) quad = 2;
      else if (px[i] * 4 > sumx && py[i] * 4 < sumy) quad = 3;
      if (quad >= 0) begin
        cnt[quad]++;
        qx[quad] = px[i];
        qy[quad] = py[i];
      end
    end
    r = rsp(MATCH_BAD, '0, '0);
    if (cnt[0] == 1 && cnt[1] == 1 && cnt[2] == 1 && cnt[3] == 1) begin
      min2 = longint'(min_side) * longint'(min_side) << (2 * FRAC_W);
      near2 = longint'(near_side) * longint'(near_side) << (2 * FRAC_W);
      for (int i = 0; i < 4; i++) begin
        sx[i] = qx[i] - qx[(i + 1) % 4];
        sy[i] = qy[i] - qy[(i + 1) % 4];
      end
      for (int i = 0; i < 4; i++) begin
        j = (i + 1) % 4;
        len2 = sx[i] * sx[i] + sy[i] * sy[i];
        if (turn_in_window(sx[i], sy[i], sx[j], sy[j])) angles++;
        if (len2 > min2) longs++;
        if (len2 < near2) nears++;
      end
      if (angles == 4 && longs == 4) r.match_code = MATCH_ACCEPT;
      else if (nears == 4) r.match_code = MATCH_GOOD;
      if (r.match_code != MATCH_BAD) begin
        r.center_x = coord_t'(sumx >>> 2);
        r.center_y = coord_t'(sumy >>> 2);
      end
    end
    return r;
  endfunction

  function automatic longint spread(longint lim);
    return longint'($urandom_range(0, 32'(2 * lim))) - lim;
  endfunction

  function automatic coord_t sat(longint v);
    if (v > 32767) return coord_t'(32767);
    if (v < -32768) return coord_t'(-32768);
    return coord_t'(v);
  endfunction

  // mostly jittered, rotated rectangles; also loose quadrilaterals, crowded sets and raw bits
  function automatic in_req_t random_quad();
    int unsigned kind, span, pick;
    longint cx, cy, ux, uy, vx, vy, jit, tx, ty;
    longint xs[4], ys[4];
    int k;
    kind = $urandom_range(0, 99);
    case ($urandom_range(0, 3))
      0: span = 60;
      1: span = 900;
      2: span = 4000;
      default: span = 15000;
    endcase
    cx = spread(16000);
    cy = spread(16000);
    if (kind >= 90) return in_req_t'({$urandom, $urandom, $urandom, $urandom});
    if (kind < 55) begin
      ux = longint'($urandom_range(span / 4 + 1, span));
      uy = spread(ux / 2);
      k = $urandom_range(4, 16);
      vx = -uy * k / 8;
      vy = ux * k / 8;
      jit = longint'($urandom_range(0, 1) ? 0 : span / 20);
      xs[0] = cx + ux + vx + spread(jit); ys[0] = cy + uy + vy + spread(jit);
      xs[1] = cx + ux - vx + spread(jit); ys[1] = cy + uy - vy + spread(jit);
      xs[2] = cx - ux - vx + spread(jit); ys[2] = cy - uy - vy + spread(jit);
      xs[3] = cx - ux + vx + spread(jit); ys[3] = cy - uy + vy + spread(jit);
    end else begin
      xs[0] = cx - $urandom_range(1, span); ys[0] = cy - $urandom_range(1, span);
      xs[1] = cx - $urandom_range(1, span); ys[1] = cy + $urandom_range(1, span);
      xs[2] = cx + $urandom_range(1, span); ys[2] = cy + $urandom_range(1, span);
      xs[3] = cx + $urandom_range(1, span); ys[3] = cy - $urandom_range(1, span);
      if (kind >= 80) begin
        pick = $urandom_range(0, 2);
        xs[3] = xs[pick];
        ys[3] = ys[pick];
      end
    end
    for (k = 3; k > 0; k--) begin
      pick = $urandom_range(0, k);
      tx = xs[k]; ty = ys[k];
      xs[k] = xs[pick]; ys[k] = ys[pick];
      xs[pick] = tx; ys[pick] = ty;
    end
    return make_quad(sat(xs[0]), sat(ys[0]), sat(xs[1]), sat(ys[1]),
                     sat(xs[2]), sat(ys[2]), sat(xs[3]), sat(ys[3]));
  endfunction

  task automatic send_corners(input in_req_t req, input bit typed, input out_rsp_t typed_rsp);
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    expected_rsp.insert(expected_rsp.size(),
                        typed ? typed_rsp : classify_quad(req, min_side_px, near_side_px));
  endtask

  task automatic pace_sender(input bit phase_end);
    if (burst_left > 0) burst_left--;
    if (burst_left == 0 || phase_end) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 12);
    end
  endtask

  task automatic write_side_limits(input logic [LIM_W-1:0] min_side,
                                   input logic [LIM_W-1:0] near_side);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MIN_SIDE;
    cfg_data <= min_side;
    do @(posedge clk); while (!cfg_ready);
    min_side_px = min_side;
    cfg_index <= CFG_NEAR_SIDE;
    cfg_data <= near_side;
    do @(posedge clk); while (!cfg_ready);
    near_side_px = near_side;
    cfg_valid <= 1'b0;
  endtask

  // receiver stall pattern: free-flowing, patchy, light, or held off for a while
  always @(posedge clk) begin
    if (stall_run == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_run <= $urandom_range(1, 60);
    end else begin
      stall_run <= stall_run - 1;
    end
    case (stall_mode)
      0: out_stall <= 1'b0;
      1: out_stall <= 1'($urandom_range(0, 1));
      2: out_stall <= ($urandom_range(0, 7) == 0);
      default: out_stall <= 1'b1;
    endcase
  end

  always @(posedge clk) begin
    out_rsp_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_rsp.size() == 0) begin
        $display("%0t: result with nothing expected, got code %0d centre %0d,%0d", $time,
                 out_data.match_code, out_data.center_x, out_data.center_y);
        mismatches++;
      end else begin
        want = expected_rsp.pop_front();
        if (out_data.match_code !== want.match_code) begin
          $display("%0t: match_code expected %0d, got %0d", $time, want.match_code,
                   out_data.match_code);
          mismatches++;
        end
        if (out_data.center_x !== want.center_x) begin
          $display("%0t: center_x expected %0d, got %0d", $time, want.center_x,
                   out_data.center_x);
          mismatches++;
        end
        if (out_data.center_y !== want.center_y) begin
          $display("%0t: center_y expected %0d, got %0d", $time, want.center_y,
                   out_data.center_y);
          mismatches++;
        end
      end
    end
  end

  initial begin
    logic [LIM_W-1:0] min_set[Phases];
    logic [LIM_W-1:0] near_set[Phases];
    out_rsp_t         none;
    none = rsp(MATCH_BAD, '0, '0);
    // all corners coincide: nothing lies strictly off the centroid lines
    add_row(make_quad(0, 0, 0, 0, 0, 0, 0, 0), 1'b1, none);
    add_row(make_quad(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767), 1'b1, none);
    // square of 200 px about the origin, corners out of order
    add_row(make_quad(1600, 1600, -1600, -1600, 1600, -1600, -1600, 1600), 1'b1,
            rsp(MATCH_ACCEPT, 0, 0));
    // full-range square, centroid floors to -1
    add_row(make_quad(-32768, -32768, -32768, 32767, 32767, 32767, 32767, -32768), 1'b1,
            rsp(MATCH_ACCEPT, -1, -1));
    add_row(make_quad(0, 0, 0, 160, 160, 160, 160, 0), 1'b1, rsp(MATCH_GOOD, 80, 80));
    // three corners in one quadrant
    add_row(make_quad(0, 0, 16, 0, 0, 16, 1600, 1600), 1'b1, none);
    // kite with every corner on a centroid line
    add_row(make_quad(0, -160, -160, 0, 0, 160, 160, 0), 1'b1, none);
    // skewed parallelogram, long sides: angles fail
    add_row(make_quad(-3200, -1600, -1600, 1600, 3200, 1600, 1600, -1600), 1'b1, none);
    add_row(make_quad(-320, -160, -160, 160, 320, 160, 160, -160), 1'b1,
            rsp(MATCH_GOOD, 0, 0));
    // side exactly at the minimum is not long enough; one pixel more is
    add_row(make_quad(0, 0, 0, 800, 800, 800, 800, 0), 1'b1, rsp(MATCH_GOOD, 400, 400));
    add_row(make_quad(0, 0, 0, 816, 816, 816, 816, 0), 1'b1, rsp(MATCH_ACCEPT, 408, 408));
    // parallel consecutive sides: zero cross product
    add_row(make_quad(-100, -300, -50, 100, 50, 900, 100, -600), 1'b0, none);
    add_row(make_quad(-1700, -1600, -1600, 1600, 1700, 1600, 1600, -1600), 1'b0, none);
    add_row(make_quad(800, 1200, 1200, -800, -1200, 800, -800, -1200), 1'b0, none);
    add_row(make_quad(-2000, -1650, -1750, 1700, 1900, 1600, 1700, -1800), 1'b0, none);
    add_row(make_quad(-32768, 100, -100, 32767, 32767, -100, 100, -32768), 1'b0, none);
    add_row(make_quad(-5, -7, -9, 3, 6, 8, 4, -6), 1'b0, none);

    min_set[0] = 12'd0;    near_set[0] = 12'd4095;
    min_set[1] = 12'd4095; near_set[1] = 12'd0;
    min_set[2] = LIM_W'($urandom_range(0, 4095)); near_set[2] = LIM_W'($urandom_range(0, 4095));
    min_set[3] = LIM_W'($urandom_range(0, 300));  near_set[3] = LIM_W'($urandom_range(0, 1200));
    min_set[4] = 12'd50;   near_set[4] = 12'd100;

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (corner_table[i]) begin
      send_corners(corner_table[i].req, corner_table[i].typed, corner_table[i].rsp);
      pace_sender(i == corner_table.size() - 1);
    end
    for (int p = 0; p < Phases; p++) begin
      while (expected_rsp.size() != 0) @(posedge clk);
      write_side_limits(min_set[p], near_set[p]);
      for (int n = 0; n < PhaseItems; n++) begin
        send_corners(random_quad(), 1'b0, none);
        pace_sender(n == PhaseItems - 1);
      end
    end
    while (expected_rsp.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
